/* src/bitmap_text_row_generator_assert.svh */
// Assertion macros shared by the text row generator modules.
`ifndef BITMAP_TEXT_ROW_GENERATOR_ASSERT_SVH
`define BITMAP_TEXT_ROW_GENERATOR_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define BTRG_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("text row generator check failed");

// Next-cycle implication, checked out of reset.
`define BTRG_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("text row generator check failed");

`endif

/* src/btrg_pkg.sv */
// Types and constants shared by the text row generator modules.
package btrg_pkg;

    // Input item as seen on the push side.
    typedef struct packed {
        logic        cmd;
        logic [14:0] font_addr;
        logic [7:0]  font_byte;
        logic [7:0]  character;
        logic        first;
    } t_in;

    // One glyph row as seen on the pop side.
    typedef struct packed {
        logic signed [15:0] pixel_x;
        logic signed [15:0] pixel_y;
        logic [47:0]        coverage_row;
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
        logic               last_row;
    } t_out;

    // Operation codes handed from the front part to the back part.
    typedef logic [1:0] t_op;
    localparam t_op OP_FONT    = 2'd0;
    localparam t_op OP_DRAW    = 2'd1;
    localparam t_op OP_NEWLINE = 2'd2;
    localparam t_op OP_SKIP    = 2'd3;

    // Classified item in the queue between front and back.
    typedef struct packed {
        t_op         op;
        logic        first;
        logic [7:0]  glyph;
        logic [14:0] font_addr;
        logic [14:0] row_addr;
        logic [7:0]  font_byte;
    } t_cmd;

    // Configuration register file contents.
    typedef struct packed {
        logic signed [15:0] origin_x;
        logic signed [15:0] origin_y;
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
    } t_cfg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx REG_ORIGIN_X   = 3'd0;
    localparam t_cfg_idx REG_ORIGIN_Y   = 3'd1;
    localparam t_cfg_idx REG_TEXT_RED   = 3'd2;
    localparam t_cfg_idx REG_TEXT_GREEN = 3'd3;
    localparam t_cfg_idx REG_TEXT_BLUE  = 3'd4;

    // Character codes.
    localparam logic [7:0] CH_NEWLINE     = 8'h0A;
    localparam logic [7:0] CH_SPACE       = 8'h20;
    localparam logic [7:0] CH_FIRST_GLYPH = 8'h21;
    localparam logic [7:0] CH_LAST_GLYPH  = 8'h7E;
    localparam logic [7:0] SPACE_GLYPH    = 8'd157;

    // Coverage row holds at most this many 4-bit columns.
    localparam int COV_COLS = 12;
    localparam int COV_W    = 4 * COV_COLS;

    // Queue depths.
    localparam int FQ_DEPTH = 2;
    localparam int OQ_DEPTH = 4;
    localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

endpackage

/* src/btrg_front.sv */
// Front part: classifies input items and queues them for the back part.
`include "bitmap_text_row_generator_assert.svh"

module btrg_front #(
    parameter int GLYPH_ROWS  = 24,
    parameter int GLYPH_COLS  = 12,
    parameter int GLYPH_COUNT = 158
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  btrg_pkg::t_in   i_item,
    output logic            o_full,
    output btrg_pkg::t_cmd  o_head,
    output logic            o_head_valid,
    input  logic            i_pop
);
    import btrg_pkg::*;

    localparam int RB          = GLYPH_COLS / 2;
    localparam int STORE_DEPTH = GLYPH_COUNT * GLYPH_ROWS * RB;
    localparam int RECIP_SH    = 18;
    localparam int PROD_W      = 15 + RECIP_SH;
    localparam logic [RECIP_SH-1:0] RECIP_K =
        RECIP_SH'(((1 << RECIP_SH) + RB - 1) / RB);
    localparam logic [16:0] DEPTH_K = 17'(STORE_DEPTH);
    localparam int PW = (FQ_DEPTH > 1) ? $clog2(FQ_DEPTH) : 1;
    localparam int CW = $clog2(FQ_DEPTH + 1);

    t_cmd              r_q [FQ_DEPTH];
    logic [PW-1:0]     r_wp;
    logic [PW-1:0]     r_rp;
    logic [CW-1:0]     r_cnt;
    logic [PROD_W-1:0] w_prod;
    logic              w_in_range;
    logic              w_push;
    logic              w_pop;
    t_cmd              w_cmd;

    // Row address = byte address / row bytes, by reciprocal multiply.
    assign w_prod     = {{RECIP_SH{1'b0}}, i_item.font_addr} * {15'd0, RECIP_K};
    assign w_in_range = {2'b00, i_item.font_addr} < DEPTH_K;

    always_comb begin
        w_cmd           = '0;
        w_cmd.font_addr = i_item.font_addr;
        w_cmd.font_byte = i_item.font_byte;
        w_cmd.row_addr  = w_prod[PROD_W-1:RECIP_SH];
        if (!i_item.cmd) begin
            w_cmd.op = w_in_range ? OP_FONT : OP_SKIP;
        end else begin
            w_cmd.first = i_item.first;
            if (i_item.character == CH_NEWLINE) begin
                w_cmd.op = OP_NEWLINE;
            end else if (i_item.character >= CH_FIRST_GLYPH &&
                         i_item.character <= CH_LAST_GLYPH) begin
                w_cmd.op    = OP_DRAW;
                w_cmd.glyph = i_item.character - CH_FIRST_GLYPH;
            end else if (i_item.character == CH_SPACE) begin
                w_cmd.op    = OP_DRAW;
                w_cmd.glyph = SPACE_GLYPH;
            end else begin
                w_cmd.op = OP_SKIP;
            end
        end
    end

    assign o_full       = (r_cnt == CW'(FQ_DEPTH));
    assign o_head_valid = (r_cnt != '0);
    assign o_head       = r_q[r_rp];
    assign w_push       = i_push && !o_full;
    assign w_pop        = i_pop && o_head_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= (r_wp == PW'(FQ_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= (r_rp == PW'(FQ_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    `BTRG_ASSERT_NEXT(a_fq_fill, w_push && !w_pop, r_cnt == $past(r_cnt) + CW'(1))

endmodule

/* src/btrg_back.sv */
// Back part: executes queued items, holds the glyph store, reads glyph rows.
`include "bitmap_text_row_generator_assert.svh"

module btrg_back #(
    parameter int GLYPH_ROWS  = 24,
    parameter int GLYPH_COLS  = 12,
    parameter int GLYPH_COUNT = 158,
    parameter int LINE_PITCH  = 31
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  btrg_pkg::t_cmd                i_head,
    input  logic                          i_head_valid,
    output logic                          o_pop,
    input  btrg_pkg::t_cfg                i_cfg,
    input  logic [btrg_pkg::OQ_CNT_W-1:0] i_oq_count,
    output logic                          o_push,
    output btrg_pkg::t_out                o_item
);
    import btrg_pkg::*;

    localparam int RB        = GLYPH_COLS / 2;
    localparam int NROWS     = GLYPH_COUNT * GLYPH_ROWS;
    localparam int AW        = $clog2(NROWS);
    localparam int RW        = $clog2(GLYPH_ROWS);
    localparam int BW        = (RB > 1) ? $clog2(RB) : 1;
    localparam int NCOL      = (GLYPH_COLS < COV_COLS) ? GLYPH_COLS : COV_COLS;
    localparam bit ODD_EXTRA = (GLYPH_COLS % 2 == 1) && (GLYPH_COLS <= COV_COLS);
    localparam logic [RW-1:0] LAST_ROW = RW'(GLYPH_ROWS - 1);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_ROWS = 1'b1;

    function automatic logic signed [15:0] sat16(input logic signed [16:0] v);
        if (v > 17'sd32767) begin
            return 16'sh7FFF;
        end else if (v < -17'sd32768) begin
            return 16'sh8000;
        end
        return v[15:0];
    endfunction

    logic                r_state;
    logic [RW-1:0]       r_row;
    logic [AW-1:0]       r_t;
    logic signed [15:0]  r_cx;
    logic signed [15:0]  r_cy;
    logic signed [15:0]  r_draw_x;
    logic signed [15:0]  r_draw_y;
    logic                r_s1_valid;
    logic signed [15:0]  r_s1_x;
    logic signed [15:0]  r_s1_y;
    logic [7:0]          r_s1_red;
    logic [7:0]          r_s1_green;
    logic [7:0]          r_s1_blue;
    logic                r_s1_last;

    logic signed [15:0]  w_eff_x;
    logic signed [15:0]  w_eff_y;
    logic [14:0]         w_rem;
    logic [BW-1:0]       w_bank;
    logic                w_wr_en;
    logic                w_issue;
    logic                w_start;
    logic [OQ_CNT_W:0]   w_room_sum;
    logic [7:0]          w_rd_bytes [RB];
    logic [7:0]          w_rd_extra;
    logic [COV_W-1:0]    w_cov;

    assign o_pop   = (r_state == ST_IDLE) && i_head_valid;
    assign w_start = o_pop && (i_head.op == OP_DRAW);
    assign w_eff_x = i_head.first ? i_cfg.origin_x : r_cx;
    assign w_eff_y = i_head.first ? i_cfg.origin_y : r_cy;

    // Bank = byte address minus row address times row bytes.
    assign w_rem   = i_head.font_addr - 15'(i_head.row_addr * RB);
    assign w_bank  = w_rem[BW-1:0];
    assign w_wr_en = o_pop && (i_head.op == OP_FONT);

    // Issue a row read only when the output queue has room for it.
    assign w_room_sum = {1'b0, i_oq_count} + (OQ_CNT_W + 1)'(r_s1_valid);
    assign w_issue    = (r_state == ST_ROWS) && (w_room_sum < (OQ_CNT_W + 1)'(OQ_DEPTH));

    // One byte-wide bank per byte of a glyph row.
    for (genvar b = 0; b < RB; b++) begin : g_bank
        logic [7:0] r_mem [NROWS];
        logic [7:0] r_rd;

        always_ff @(posedge i_clk) begin
            if (w_wr_en && w_bank == BW'(b)) begin
                r_mem[i_head.row_addr[AW-1:0]] <= i_head.font_byte;
            end
            if (w_issue) begin
                r_rd <= r_mem[r_t];
            end
        end
        assign w_rd_bytes[b] = r_rd;

        // Odd width: the last column sits in byte zero of the next row.
        if (b == 0 && ODD_EXTRA) begin : g_extra
            logic [7:0] r_rd_next;
            logic       r_next_oob;
            logic [AW:0] w_t_next;

            assign w_t_next = {1'b0, r_t} + 1'b1;

            always_ff @(posedge i_clk) begin
                if (w_issue) begin
                    r_rd_next  <= r_mem[w_t_next[AW-1:0]];
                    r_next_oob <= (w_t_next == (AW + 1)'(NROWS));
                end
            end
            assign w_rd_extra = r_next_oob ? 8'd0 : r_rd_next;
        end
    end

    if (!ODD_EXTRA) begin : g_no_extra
        assign w_rd_extra = 8'd0;
    end

    // Unpack nibbles: even column in the low nibble, odd in the high.
    for (genvar c = 0; c < COV_COLS; c++) begin : g_col
        if (c < NCOL) begin : g_used
            logic [7:0] w_byte;
            if (c / 2 < RB) begin : g_own
                assign w_byte = w_rd_bytes[c / 2];
            end else begin : g_next
                assign w_byte = w_rd_extra;
            end
            if (c % 2 == 0) begin : g_lo
                assign w_cov[4*c +: 4] = w_byte[3:0];
            end else begin : g_hi
                assign w_cov[4*c +: 4] = w_byte[7:4];
            end
        end else begin : g_unused
            assign w_cov[4*c +: 4] = 4'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_row      <= '0;
            r_cx       <= '0;
            r_cy       <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= w_issue;
            unique case (r_state)
                ST_IDLE: begin
                    if (o_pop) begin
                        unique case (i_head.op)
                            OP_FONT: begin
                                r_cx <= r_cx;
                            end
                            OP_NEWLINE: begin
                                r_cx <= i_cfg.origin_x;
                                r_cy <= sat16($signed({w_eff_y[15], w_eff_y}) +
                                              $signed(17'(LINE_PITCH)));
                            end
                            OP_SKIP: begin
                                r_cx <= w_eff_x;
                                r_cy <= w_eff_y;
                            end
                            OP_DRAW: begin
                                r_cy    <= w_eff_y;
                                r_cx    <= sat16($signed({w_eff_x[15], w_eff_x}) +
                                                 $signed(17'(GLYPH_COLS)));
                                r_row   <= '0;
                                r_state <= ST_ROWS;
                            end
                            default: begin
                                r_cx <= r_cx;
                            end
                        endcase
                    end
                end
                ST_ROWS: begin
                    if (w_issue) begin
                        r_row <= r_row + 1'b1;
                        if (r_row == LAST_ROW) begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Row pointer, draw position and the row's side data.
    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_t      <= AW'(i_head.glyph * GLYPH_ROWS);
            r_draw_x <= w_eff_x;
            r_draw_y <= w_eff_y;
        end else if (w_issue) begin
            r_t <= r_t + 1'b1;
        end
        if (w_issue) begin
            r_s1_x     <= r_draw_x;
            r_s1_y     <= sat16($signed({r_draw_y[15], r_draw_y}) +
                                $signed({{(17 - RW){1'b0}}, r_row}));
            r_s1_red   <= i_cfg.red;
            r_s1_green <= i_cfg.green;
            r_s1_blue  <= i_cfg.blue;
            r_s1_last  <= (r_row == LAST_ROW);
        end
    end

    assign o_push              = r_s1_valid;
    assign o_item.pixel_x      = r_s1_x;
    assign o_item.pixel_y      = r_s1_y;
    assign o_item.coverage_row = w_cov;
    assign o_item.red          = r_s1_red;
    assign o_item.green        = r_s1_green;
    assign o_item.blue         = r_s1_blue;
    assign o_item.last_row     = r_s1_last;

    `BTRG_ASSERT_IMPL(a_push_room, r_s1_valid, i_oq_count < OQ_CNT_W'(OQ_DEPTH))
    `BTRG_ASSERT_NEXT(a_draw_start, w_start, r_state == ST_ROWS && r_row == '0)
    `BTRG_ASSERT_NEXT(a_last_row, w_issue && r_row == LAST_ROW, r_state == ST_IDLE && r_s1_last)

endmodule

/* src/btrg_outq.sv */
// Output queue: holds finished glyph rows until the consumer pops them.
`include "bitmap_text_row_generator_assert.svh"

module btrg_outq (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    input  btrg_pkg::t_out                i_item,
    output logic                          o_empty,
    output btrg_pkg::t_out                o_item,
    input  logic                          i_pop,
    output logic [btrg_pkg::OQ_CNT_W-1:0] o_count
);
    import btrg_pkg::*;

    localparam int PW = $clog2(OQ_DEPTH);

    t_out                r_q [OQ_DEPTH];
    logic [PW-1:0]       r_wp;
    logic [PW-1:0]       r_rp;
    logic [OQ_CNT_W-1:0] r_cnt;
    logic                w_pop;

    assign o_empty = (r_cnt == '0);
    assign o_item  = r_q[r_rp];
    assign o_count = r_cnt;
    assign w_pop   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PW'(OQ_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= (r_rp == PW'(OQ_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            case ({i_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    `BTRG_ASSERT_IMPL(a_oq_no_overflow, i_push && !w_pop, r_cnt < OQ_CNT_W'(OQ_DEPTH))

endmodule

/* src/bitmap_text_row_generator.sv */
// Top level of the bitmap text row generator.
//
//  channel   direction  handshake          payload
//  --------  ---------  -----------------  --------------------------------------
//  input     in         push / full        i_in  : cmd, font_addr, font_byte, ...
//  result    out        empty / pop        o_out : pixel_x, pixel_y, coverage_row,...
//  config    in         cfg valid / ready  i_cfg_index, i_cfg_data
//
//  A font write, a newline or an ignored byte is executed as it is popped. A
//  drawn glyph is dispatched, then read a row per cycle while the output queue
//  has room, by one read of the banked glyph store (GLYPH_COLS/2 byte banks).
//  Reset is synchronous: it clears the cursor, the queues and the config
//  registers (colour to white); the glyph store is not cleared.
//  The input side takes items while the two-entry front queue has room, even
//  while rows are waiting; row reads pause when the four-entry output queue
//  cannot take the next row.
module bitmap_text_row_generator #(
    parameter int GLYPH_ROWS  = 24,
    parameter int GLYPH_COLS  = 12,
    parameter int GLYPH_COUNT = 158,
    parameter int LINE_PITCH  = 31
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            push,
    output logic                            full,
    input  btrg_pkg::t_in                   i_in,
    output logic                            empty,
    input  logic                            pop,
    output btrg_pkg::t_out                  o_out,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [btrg_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [btrg_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import btrg_pkg::*;

    t_cfg                r_cfg;
    t_cmd                w_head;
    logic                w_head_valid;
    logic                w_head_pop;
    logic                w_row_push;
    t_out                w_row;
    logic [OQ_CNT_W-1:0] w_oq_count;

    // Config writes always complete; user must keep them to while the block is idle.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.origin_x <= '0;
            r_cfg.origin_y <= '0;
            r_cfg.red      <= 8'hFF;
            r_cfg.green    <= 8'hFF;
            r_cfg.blue     <= 8'hFF;
        end else if (i_cfg_valid) begin
            // Decode register index; drop writes beyond the register list.
            unique case (i_cfg_index)
                REG_ORIGIN_X:   r_cfg.origin_x <= i_cfg_data;
                REG_ORIGIN_Y:   r_cfg.origin_y <= i_cfg_data;
                REG_TEXT_RED:   r_cfg.red      <= i_cfg_data[7:0];
                REG_TEXT_GREEN: r_cfg.green    <= i_cfg_data[7:0];
                REG_TEXT_BLUE:  r_cfg.blue     <= i_cfg_data[7:0];
                default:        r_cfg          <= r_cfg;
            endcase
        end
    end

    // Classify items and hold them for the back end.
    btrg_front #(
        .GLYPH_ROWS  (GLYPH_ROWS),
        .GLYPH_COLS  (GLYPH_COLS),
        .GLYPH_COUNT (GLYPH_COUNT)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_item       (i_in),
        .o_full       (full),
        .o_head       (w_head),
        .o_head_valid (w_head_valid),
        .i_pop        (w_head_pop)
    );

    // Execute items: font writes, cursor moves and glyph row reads.
    btrg_back #(
        .GLYPH_ROWS  (GLYPH_ROWS),
        .GLYPH_COLS  (GLYPH_COLS),
        .GLYPH_COUNT (GLYPH_COUNT),
        .LINE_PITCH  (LINE_PITCH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (w_head),
        .i_head_valid (w_head_valid),
        .o_pop        (w_head_pop),
        .i_cfg        (r_cfg),
        .i_oq_count   (w_oq_count),
        .o_push       (w_row_push),
        .o_item       (w_row)
    );

    // Hold finished rows for the consumer.
    btrg_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_row_push),
        .i_item  (w_row),
        .o_empty (empty),
        .o_item  (o_out),
        .i_pop   (pop),
        .o_count (w_oq_count)
    );

endmodule
